@@ rtl/core/tic_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tic_pkg
// Types, edge tables and helpers shared by the triangle isoline cell.
// ----------------------------------------------------------------------------
package tic_pkg;

  localparam int unsigned ValW   = 16;
  localparam int unsigned CoordW = 16;
  localparam int unsigned SpanW  = 16;   // |a - b| of two 16-bit signed values

  typedef struct packed {
    logic signed [ValW-1:0]   value_a;
    logic signed [ValW-1:0]   value_b;
    logic signed [ValW-1:0]   value_c;
    logic        [CoordW-1:0] x_a;
    logic        [CoordW-1:0] y_a;
    logic        [CoordW-1:0] x_b;
    logic        [CoordW-1:0] y_b;
    logic        [CoordW-1:0] x_c;
    logic        [CoordW-1:0] y_c;
  } tic_in_t;

  typedef struct packed {
    logic              has_segment;
    logic [2:0]        case_code;
    logic [1:0]        start_edge;
    logic [1:0]        end_edge;
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
  } tic_out_t;

  // Sideband that rides along the divider chain
  typedef struct packed {
    logic              has;
    logic [2:0]        code;
    logic [1:0]        se;
    logic [1:0]        ee;
    logic [CoordW-1:0] spx;
    logic [CoordW-1:0] spy;
    logic [CoordW-1:0] sqx;
    logic [CoordW-1:0] sqy;
    logic [CoordW-1:0] epx;
    logic [CoordW-1:0] epy;
    logic [CoordW-1:0] eqx;
    logic [CoordW-1:0] eqy;
  } tic_side_t;

  localparam logic [1:0] Edge0 = 2'd0;
  localparam logic [1:0] Edge1 = 2'd1;
  localparam logic [1:0] Edge2 = 2'd2;

  function automatic logic [1:0] start_edge_of(input logic [2:0] code);
    logic [1:0] e;
    case (code)
      3'd1:    e = Edge2;
      3'd2:    e = Edge0;
      3'd3:    e = Edge1;
      3'd4:    e = Edge2;
      3'd5:    e = Edge1;
      3'd6:    e = Edge0;
      default: e = Edge0;
    endcase
    return e;
  endfunction

  function automatic logic [1:0] end_edge_of(input logic [2:0] code);
    logic [1:0] e;
    case (code)
      3'd1:    e = Edge0;
      3'd2:    e = Edge1;
      3'd3:    e = Edge2;
      3'd4:    e = Edge1;
      3'd5:    e = Edge0;
      3'd6:    e = Edge2;
      default: e = Edge0;
    endcase
    return e;
  endfunction

  function automatic logic [SpanW-1:0] abs_diff(input logic signed [ValW-1:0] a,
                                                input logic signed [ValW-1:0] b);
    logic signed [ValW:0] d;
    d = {a[ValW-1], a} - {b[ValW-1], b};
    return d[ValW] ? SpanW'(-d) : d[SpanW-1:0];
  endfunction

endpackage

@@ rtl/core/tic_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tic_div_cell
// One restoring-division step: settles one fraction bit and hands the
// partial remainder, divisor and quotient to the next cell.
// ----------------------------------------------------------------------------
module tic_div_cell #(
  parameter int unsigned FracBits = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [tic_pkg::SpanW:0]   rem_i,
  input  logic [tic_pkg::SpanW-1:0] den_i,
  input  logic [FracBits:0]      quo_i,
  output logic [tic_pkg::SpanW:0]   rem_o,
  output logic [tic_pkg::SpanW-1:0] den_o,
  output logic [FracBits:0]      quo_o
);
  import tic_pkg::*;

  logic [SpanW:0]   rem_q, rem_d;
  logic [SpanW-1:0] den_q;
  logic [FracBits:0] quo_q, quo_d;
  logic             bit_w;
  logic [SpanW:0]   sub_w;

  always_comb begin
    bit_w = rem_i >= {1'b0, den_i};
    sub_w = bit_w ? (rem_i - {1'b0, den_i}) : rem_i;
    // remainder now below the divisor, so the shift cannot overflow
    rem_d = {sub_w[SpanW-1:0], 1'b0};
    quo_d = {quo_i[FracBits-1:0], bit_w};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      den_q <= '0;
      quo_q <= '0;
    end else if (en_i) begin
      rem_q <= rem_d;
      den_q <= den_i;
      quo_q <= quo_d;
    end
  end

  assign rem_o = rem_q;
  assign den_o = den_q;
  assign quo_o = quo_q;

endmodule

@@ rtl/core/tic_lerp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tic_lerp
// Two-stage interpolation of one coordinate: P + floor((Q - P) * f / 2^F).
// ----------------------------------------------------------------------------
module tic_lerp #(
  parameter int unsigned FracBits = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic [tic_pkg::CoordW-1:0]  p_i,
  input  logic [tic_pkg::CoordW-1:0]  q_i,
  input  logic [FracBits:0]        frac_i,
  output logic [tic_pkg::CoordW-1:0]  coord_o
);
  import tic_pkg::*;

  localparam int unsigned ProdW = CoordW + FracBits + 3;

  logic signed [CoordW:0]  diff_w;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic [CoordW-1:0]       p_q;
  logic [CoordW-1:0]       coord_q;
  logic signed [ProdW-1:0] sum_w;

  always_comb begin
    diff_w = $signed({1'b0, q_i}) - $signed({1'b0, p_i});
    prod_d = ProdW'(diff_w * $signed({1'b0, frac_i}));
    sum_w  = (prod_q >>> FracBits) + $signed(ProdW'({1'b0, p_q}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q  <= '0;
      p_q     <= '0;
      coord_q <= '0;
    end else if (en_i) begin
      prod_q  <= prod_d;
      p_q     <= p_i;
      coord_q <= sum_w[CoordW-1:0];
    end
  end

  assign coord_o = coord_q;

endmodule

@@ rtl/core/triangle_isoline_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_isoline_cell
// Marching-triangles isoline: case code, crossed edges and crossing points.
// ----------------------------------------------------------------------------
// Pipeline from input word to output word: one setup stage,
// FRACTION_BITS + 1 division cells, multiply, add.
// Throughput: one triangle per cycle while the output is taken; the division chain is fully pipelined.
// The whole pipe holds while the output word waits.
// Reset clears all valid bits and sets the iso level to 0.
module triangle_isoline_cell #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tic_pkg::tic_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tic_pkg::tic_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [15:0]       cfg_data_i
);
  import tic_pkg::*;

  localparam int unsigned Cells = FRACTION_BITS + 1;

  logic                    adv_w;
  logic signed [ValW-1:0]  iso_q;

  // setup stage signals
  logic [2:0]              code_w;
  logic [1:0]              se_w, ee_w;
  logic [1:0]              sp_w, ep_w;
  logic signed [ValW-1:0]  val_w [3];
  logic [CoordW-1:0]       xs_w [3];
  logic [CoordW-1:0]       ys_w [3];
  logic [SpanW-1:0]        num_w [3];
  logic [SpanW-1:0]        den_w [3];
  tic_side_t               side_d;

  logic                    vld_q  [Cells+1];
  tic_side_t               side_q [Cells+1];
  logic [SpanW:0]          srem   [Cells+1];
  logic [SpanW-1:0]        sden   [Cells+1];
  logic [FRACTION_BITS:0]  squo   [Cells+1];
  logic [SpanW:0]          erem   [Cells+1];
  logic [SpanW-1:0]        eden   [Cells+1];
  logic [FRACTION_BITS:0]  equo   [Cells+1];
  logic [SpanW:0]          srem_q, erem_q;
  logic [SpanW-1:0]        sden_q, eden_q;

  logic                    mvld_q, ovld_q;
  logic [7:0]              mhdr_q, ohdr_q;   // has, code, se, ee
  logic [CoordW-1:0]       sx_w, sy_w, ex_w, ey_w;

  assign adv_w       = !ovld_q || out_ready_i;
  assign in_ready_o  = adv_w;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    val_w[0] = in_data_i.value_a;
    val_w[1] = in_data_i.value_b;
    val_w[2] = in_data_i.value_c;
    xs_w[0]  = in_data_i.x_a;
    xs_w[1]  = in_data_i.x_b;
    xs_w[2]  = in_data_i.x_c;
    ys_w[0]  = in_data_i.y_a;
    ys_w[1]  = in_data_i.y_b;
    ys_w[2]  = in_data_i.y_c;
    for (int e = 0; e < 3; e++) begin
      code_w[e] = val_w[e] < iso_q;
      // edge e runs from vertex (e+1) mod 3 to vertex e
      num_w[e]  = abs_diff(iso_q, val_w[(e + 1) % 3]);
      den_w[e]  = abs_diff(val_w[e], val_w[(e + 1) % 3]);
    end
    se_w = start_edge_of(code_w);
    ee_w = end_edge_of(code_w);
    sp_w = (se_w == Edge2) ? 2'd0 : se_w + 2'd1;
    ep_w = (ee_w == Edge2) ? 2'd0 : ee_w + 2'd1;
    side_d.has  = (code_w != 3'd0) && (code_w != 3'd7);
    side_d.code = code_w;
    side_d.se   = se_w;
    side_d.ee   = ee_w;
    side_d.spx  = xs_w[sp_w];
    side_d.spy  = ys_w[sp_w];
    side_d.sqx  = xs_w[se_w];
    side_d.sqy  = ys_w[se_w];
    side_d.epx  = xs_w[ep_w];
    side_d.epy  = ys_w[ep_w];
    side_d.eqx  = xs_w[ee_w];
    side_d.eqy  = ys_w[ee_w];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iso_q <= '0;
    end else if (cfg_valid_i) begin
      iso_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= Cells; k++) vld_q[k] <= 1'b0;
    end else if (adv_w) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k <= Cells; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_w) begin
      side_q[0] <= side_d;
      srem_q    <= {1'b0, num_w[se_w]};
      sden_q    <= den_w[se_w];
      erem_q    <= {1'b0, num_w[ee_w]};
      eden_q    <= den_w[ee_w];
      for (int k = 1; k <= Cells; k++) side_q[k] <= side_q[k-1];
    end
  end

  assign srem[0] = srem_q;
  assign sden[0] = sden_q;
  assign squo[0] = '0;
  assign erem[0] = erem_q;
  assign eden[0] = eden_q;
  assign equo[0] = '0;

  for (genvar k = 0; k < Cells; k++) begin : g_div
    tic_div_cell #(.FracBits(FRACTION_BITS)) u_start (
      .clk_i, .rst_ni, .en_i(adv_w),
      .rem_i(srem[k]), .den_i(sden[k]), .quo_i(squo[k]),
      .rem_o(srem[k+1]), .den_o(sden[k+1]), .quo_o(squo[k+1])
    );
    tic_div_cell #(.FracBits(FRACTION_BITS)) u_end (
      .clk_i, .rst_ni, .en_i(adv_w),
      .rem_i(erem[k]), .den_i(eden[k]), .quo_i(equo[k]),
      .rem_o(erem[k+1]), .den_o(eden[k+1]), .quo_o(equo[k+1])
    );
  end

  tic_lerp #(.FracBits(FRACTION_BITS)) u_sx (
    .clk_i, .rst_ni, .en_i(adv_w), .p_i(side_q[Cells].spx), .q_i(side_q[Cells].sqx),
    .frac_i(squo[Cells]), .coord_o(sx_w)
  );
  tic_lerp #(.FracBits(FRACTION_BITS)) u_sy (
    .clk_i, .rst_ni, .en_i(adv_w), .p_i(side_q[Cells].spy), .q_i(side_q[Cells].sqy),
    .frac_i(squo[Cells]), .coord_o(sy_w)
  );
  tic_lerp #(.FracBits(FRACTION_BITS)) u_ex (
    .clk_i, .rst_ni, .en_i(adv_w), .p_i(side_q[Cells].epx), .q_i(side_q[Cells].eqx),
    .frac_i(equo[Cells]), .coord_o(ex_w)
  );
  tic_lerp #(.FracBits(FRACTION_BITS)) u_ey (
    .clk_i, .rst_ni, .en_i(adv_w), .p_i(side_q[Cells].epy), .q_i(side_q[Cells].eqy),
    .frac_i(equo[Cells]), .coord_o(ey_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvld_q <= 1'b0;
      ovld_q <= 1'b0;
    end else if (adv_w) begin
      mvld_q <= vld_q[Cells];
      ovld_q <= mvld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_w) begin
      mhdr_q <= {side_q[Cells].has, side_q[Cells].code, side_q[Cells].se, side_q[Cells].ee};
      ohdr_q <= mhdr_q;
    end
  end

  // drop everything but has_segment and the code when no segment
  always_comb begin
    out_data_o.has_segment = ohdr_q[7];
    out_data_o.case_code   = ohdr_q[6:4];
    out_data_o.start_edge  = ohdr_q[7] ? ohdr_q[3:2] : 2'd0;
    out_data_o.end_edge    = ohdr_q[7] ? ohdr_q[1:0] : 2'd0;
    out_data_o.start_x     = ohdr_q[7] ? sx_w : '0;
    out_data_o.start_y     = ohdr_q[7] ? sy_w : '0;
    out_data_o.end_x       = ohdr_q[7] ? ex_w : '0;
    out_data_o.end_y       = ohdr_q[7] ? ey_w : '0;
  end

  assign out_valid_o = ovld_q;

endmodule
